/* hw/rtl/kvt_pkg.sv */
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants of the key/value table
// Table size, operation and status codes, and the lookup result struct.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef logic [TABLE_ENTRIES-1:0][KEY_W-1:0] key_array_t;

    // lookup result for one key against the whole table
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } match_t;

endpackage

`default_nettype wire

/* hw/rtl/kvt_match.sv */
// ----------------------------------------------------------------------------
// kvt_match: parallel key compare and free slot search
// Compares a key against every valid slot at once and picks the
// lowest-numbered matching slot and the lowest-numbered free slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_match
    import kvt_pkg::*;
(
    input  wire logic [KEY_W-1:0]         key,
    input  wire logic [TABLE_ENTRIES-1:0] slot_valid,
    input  wire key_array_t               slot_key,
    output match_t                        result
);

    logic [TABLE_ENTRIES-1:0] key_eq;

    // one comparator per slot
    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            key_eq[i] = slot_valid[i] && (slot_key[i] == key);
        end
    end

    // priority pick, lowest slot wins
    always_comb
    begin
        result = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (key_eq[i])
            begin
                result.hit     = 1'b1;
                result.hit_idx = IDX_W'(i);
            end
            if (!slot_valid[i])
            begin
                result.free     = 1'b1;
                result.free_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/key_value_table.sv */
// ----------------------------------------------------------------------------
// key_value_table: fixed-capacity associative key/value table
// Insert, update, delete and find on a table of 32-bit keys and values.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one request word per
//   handshake: operation, key and value. The output channel
//   (out_valid/out_ready) returns one status word per request, in order.
//   A request is captured into an input register, looked up against all
//   slots at once by the compare array, and its status lands in the result
//   register together with the table update. One request is taken every
//   cycle while the receiver does not stall; the figure is set by the
//   single compare-and-write pass over the slot registers. When the
//   receiver stalls, the status word holds in the result register
//   and the pending request holds in the input register; in_ready drops
//   only when both are occupied. Reset frees every slot at once and
//   empties both registers; the table is usable once reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table
    import kvt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                operation,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic signed [VALUE_W-1:0] value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     status
);

    // input register
    logic                      req_valid_reg;
    op_t                       req_op_reg;
    logic [KEY_W-1:0]          req_key_reg;
    logic signed [VALUE_W-1:0] req_value_reg;

    // result register
    logic                      out_valid_reg;
    status_t                   status_reg;
    status_t                   status_next;

    // table storage
    logic [TABLE_ENTRIES-1:0]  slot_valid_reg;
    logic [TABLE_ENTRIES-1:0]  slot_valid_next;
    key_array_t                slot_key_reg;
    logic signed [VALUE_W-1:0] slot_value_reg [TABLE_ENTRIES];

    logic                      advance;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_idx;
    match_t                    match;

    // flow control
    assign advance   = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // capture request word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_op_reg    <= op_t'(operation);
            req_key_reg   <= key;
            req_value_reg <= value;
        end
    end

    // lookup against all slots
    kvt_match u_match (
        .key        (req_key_reg),
        .slot_valid (slot_valid_reg),
        .slot_key   (slot_key_reg),
        .result     (match)
    );

    // operation decode and table update
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        status_next     = ST_DONE;
        wr_en           = 1'b0;
        wr_idx          = match.hit_idx;
        case (req_op_reg)
            OP_INSERT:
            begin
                if (match.hit)
                begin
                    wr_en = 1'b1;
                end
                else if (match.free)
                begin
                    wr_en                            = 1'b1;
                    wr_idx                           = match.free_idx;
                    slot_valid_next[match.free_idx] = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_UPDATE:
            begin
                if (match.hit)
                    wr_en = 1'b1;
                else
                    status_next = ST_NOT_FOUND;
            end
            OP_DELETE:
            begin
                if (match.hit)
                    slot_valid_next[match.hit_idx] = 1'b0;
                else
                    status_next = ST_NOT_FOUND;
            end
            default:
            begin
                if (!match.hit)
                    status_next = ST_NOT_FOUND;
            end
        endcase
    end

    // slot valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (advance)
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    // slot key and value, written together; on a hit the key is unchanged
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            slot_key_reg[wr_idx]   <= req_key_reg;
            slot_value_reg[wr_idx] <= req_value_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
        end
    end

`ifndef SYNTHESIS
    // table full is only reported when no slot is free
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && status_next == ST_FULL) |-> (&slot_valid_reg))
        else $error("table full reported with a free slot");

    // a successful delete frees the matched slot
    a_delete_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && req_op_reg == OP_DELETE && match.hit)
        |=> !slot_valid_reg[$past(match.hit_idx)])
        else $error("deleted slot still valid");

    // at most one slot is taken per request
    a_one_slot_per_req: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(slot_valid_reg) <= $countones($past(slot_valid_reg)) + 1))
        else $error("more than one slot filled in one cycle");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
